>>> design/srpg_pkg.sv
// Shared types, widths and constants of the sinc RF pulse generator.
package srpg_pkg;

  localparam int TIME_W  = 32;
  localparam int DUR_W   = 31;
  localparam int AMP_W   = 15;
  localparam int STEP_W  = 32;
  localparam int PHASE_W = 32;
  localparam int TRIG_W  = 31;
  localparam int UQ_W    = 46;
  localparam int NUM_W   = AMP_W + TRIG_W;
  localparam int DEN_W   = UQ_W + 16;
  localparam int QUOT_W  = 15;
  localparam int REM_W   = NUM_W + QUOT_W;

  localparam int SINE_LAT = 4;
  localparam int DIV_LAT  = QUOT_W + 1;

  localparam logic [30:0] SIN_A      = 31'd1686629713;
  localparam logic [30:0] SIN_B      = 31'd688904866;
  localparam logic [30:0] SIN_C      = 31'd76016977;
  localparam logic [30:0] Q30_ONE    = 31'd1073741824;
  localparam logic [15:0] TWO_PI_Q13 = 16'd51472;

  typedef enum logic [1:0] {
    CFG_DURATION  = 2'd0,
    CFG_AMPLITUDE = 2'd1,
    CFG_CARRIER   = 2'd2,
    CFG_BANDWIDTH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic            win;
    logic            zero;
    logic            huge;
    logic            tiny;
    logic [UQ_W-1:0] uq;
  } sine_tag_t;

  typedef struct packed {
    logic              win;
    logic              zero;
    logic              huge;
    logic              tiny;
    logic              eneg;
    logic [TRIG_W-1:0] yc;
    logic              negc;
    logic [TRIG_W-1:0] ys;
    logic              negs;
  } div_tag_t;

endpackage

>>> design/sinc_rf_pulse_generator_core.sv
// Sinc RF pulse generator: top level with config registers and pipeline control.
//
// Input channel: sample_time_i with in_valid_i / in_stall_o. One transaction
// is taken per clock while the output side moves. Output channel: in_phase_o
// and quadrature_o with out_valid_o / out_stall_i, one transaction per input.
// Throughput is one sample per cycle while the output is not stalled, set by the
// fully pipelined sine lanes (4 stages) and the one-bit-per-stage divider of the
// sinc envelope (16 stages).
// Config is written through cfg_we_i / cfg_idx_i / cfg_wdata_i, taking effect at
// once; the user must write only while the pipeline is empty (not enforced).
// Reset clears all valid bits and loads the default register values
// (duration 1000, amplitude 0.5, carrier and bandwidth steps zero).
// When the receiver stalls a valid output, the whole pipeline freezes and
// in_stall_o is raised in the same cycle; nothing is lost or repeated.
// Samples outside 0..duration give zero I and Q.
module sinc_rf_pulse_generator_core #(
  parameter int OUT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [srpg_pkg::TIME_W-1:0]  sample_time_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [OUT_BITS-1:0]          in_phase_o,
  output logic [OUT_BITS-1:0]          quadrature_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [srpg_pkg::STEP_W-1:0]  cfg_wdata_i
);
  import srpg_pkg::*;

  localparam int ST_G  = 2 + SINE_LAT;
  localparam int ST_H  = ST_G + DIV_LAT + 1;
  localparam int NST   = ST_H + 3;
  localparam int SH    = NUM_W - OUT_BITS;
  localparam int SINEW = $bits(sine_tag_t);
  localparam int DIVW  = $bits(div_tag_t);

  logic [DUR_W-1:0]  dur_q;
  logic [AMP_W-1:0]  amp_q;
  logic [STEP_W-1:0] car_q, bw_q;
  logic [NST-1:0]    v_q;
  logic              adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DUR_W'(1000);
      amp_q <= AMP_W'(16384);
      car_q <= '0;
      bw_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DURATION:  dur_q <= cfg_wdata_i[DUR_W-1:0];
        CFG_AMPLITUDE: amp_q <= cfg_wdata_i[AMP_W-1:0];
        CFG_CARRIER:   car_q <= cfg_wdata_i;
        CFG_BANDWIDTH: bw_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv        = !(v_q[NST-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  // stage A: window check and centring (t2 in half ticks)
  logic        win_a_d, win_a_q, win_b_q;
  logic [32:0] t2_a_d, t2_a_q;
  logic [31:0] a_a_d, a_a_q;
  logic [63:0] uf_b_q;
  logic [32:0] ph_b_q;

  assign win_a_d = !sample_time_i[TIME_W-1] && (sample_time_i[DUR_W-1:0] <= dur_q);
  assign t2_a_d  = {1'b0, sample_time_i[DUR_W-1:0], 1'b0} - 33'(dur_q);
  assign a_a_d   = t2_a_d[32] ? 32'(-t2_a_d) : t2_a_d[31:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      win_a_q <= win_a_d;
      t2_a_q  <= t2_a_d;
      a_a_q   <= a_a_d;
      win_b_q <= win_a_q;
      uf_b_q  <= 64'(a_a_q) * 64'(bw_q);
      ph_b_q  <= t2_a_q * 33'(car_q);
    end
  end

  // sine lanes: sinc numerator, cosine, sine
  sine_tag_t                      stag_in, stag_out;
  logic [2:0][PHASE_W-1:0]        sp;
  logic [2:0][TRIG_W-1:0]         sy;
  logic [2:0]                     sneg;

  assign stag_in.win  = win_b_q;
  assign stag_in.zero = (uf_b_q == '0);
  assign stag_in.huge = |uf_b_q[63:48];
  assign stag_in.tiny = ~|uf_b_q[63:24];
  assign stag_in.uq   = uf_b_q[47:2];
  assign sp[0] = uf_b_q[33:2];
  assign sp[1] = ph_b_q[32:1] + 32'(Q30_ONE);
  assign sp[2] = ph_b_q[32:1];

  srpg_sine #(.LANES(3), .TAG_W(SINEW)) u_sine (
    .clk_i (clk_i),
    .en_i  (adv),
    .p_i   (sp),
    .tag_i (stag_in),
    .y_o   (sy),
    .neg_o (sneg),
    .tag_o (stag_out)
  );

  // stage G: divider operands
  logic [NUM_W-1:0] num_g_q;
  logic [DEN_W-1:0] den_g_q;
  div_tag_t         dtag_g_q, dtag_out;
  logic [QUOT_W-1:0] quo;
  logic             sat;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_g_q       <= NUM_W'(amp_q) * NUM_W'(sy[0]);
      den_g_q       <= DEN_W'(stag_out.uq) * DEN_W'(TWO_PI_Q13);
      dtag_g_q.win  <= stag_out.win;
      dtag_g_q.zero <= stag_out.zero;
      dtag_g_q.huge <= stag_out.huge;
      dtag_g_q.tiny <= stag_out.tiny;
      dtag_g_q.eneg <= sneg[0];
      dtag_g_q.yc   <= sy[1];
      dtag_g_q.negc <= sneg[1];
      dtag_g_q.ys   <= sy[2];
      dtag_g_q.negs <= sneg[2];
    end
  end

  srpg_div #(.TAG_W(DIVW)) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_g_q),
    .den_i (den_g_q),
    .tag_i (dtag_g_q),
    .quo_o (quo),
    .sat_o (sat),
    .tag_o (dtag_out)
  );

  // stage H: envelope selection
  logic [AMP_W-1:0]  emag_d, emag_h_q;
  logic              eneg_h_q, negc_h_q, negs_h_q;
  logic [TRIG_W-1:0] yc_h_q, ys_h_q;

  always_comb begin
    if (!dtag_out.win || (!dtag_out.zero && dtag_out.huge)) begin
      emag_d = '0;
    end else if (dtag_out.zero || dtag_out.tiny || sat) begin
      emag_d = amp_q;
    end else if (quo > amp_q) begin
      emag_d = amp_q;
    end else begin
      emag_d = quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      emag_h_q <= emag_d;
      eneg_h_q <= dtag_out.eneg;
      yc_h_q   <= dtag_out.yc;
      negc_h_q <= dtag_out.negc;
      ys_h_q   <= dtag_out.ys;
      negs_h_q <= dtag_out.negs;
    end
  end

  // stage I: mixing products
  logic [NUM_W-1:0] pi_i_q, pq_i_q;
  logic             sgi_i_q, sgq_i_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pi_i_q  <= NUM_W'(emag_h_q) * NUM_W'(yc_h_q);
      pq_i_q  <= NUM_W'(emag_h_q) * NUM_W'(ys_h_q);
      sgi_i_q <= eneg_h_q ^ negc_h_q;
      sgq_i_q <= eneg_h_q ^ negs_h_q;
    end
  end

  // stage J: scale, sign, saturate
  function automatic logic [OUT_BITS-1:0] sat_out(input logic [NUM_W-1:0] p, input logic neg);
    logic [NUM_W-1:0]    mag;
    logic [OUT_BITS-1:0] r;
    mag = p >> SH;
    if (neg) begin
      if (mag >= (NUM_W'(1) << (OUT_BITS - 1))) r = {1'b1, {(OUT_BITS-1){1'b0}}};
      else r = -mag[OUT_BITS-1:0];
    end else begin
      if (mag >= (NUM_W'(1) << (OUT_BITS - 1))) r = {1'b0, {(OUT_BITS-1){1'b1}}};
      else r = mag[OUT_BITS-1:0];
    end
    return r;
  endfunction

  logic [OUT_BITS-1:0] i_q, q_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i_q <= sat_out(pi_i_q, sgi_i_q);
      q_q <= sat_out(pq_i_q, sgq_i_q);
    end
  end

  assign out_valid_o  = v_q[NST-1];
  assign in_phase_o   = i_q;
  assign quadrature_o = q_q;

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(v_q))
    else $error("pipeline moved during output stall");

  a_env_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_H] |-> (emag_h_q <= amp_q))
    else $error("envelope exceeds peak amplitude");
`endif

endmodule

>>> design/srpg_sine.sv
// Pipelined quarter-wave polynomial sine, several lanes sharing one side tag.
module srpg_sine #(
  parameter int LANES = 3,
  parameter int TAG_W = 1
) (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  logic [LANES-1:0][srpg_pkg::PHASE_W-1:0]     p_i,
  input  logic [TAG_W-1:0]                            tag_i,
  output logic [LANES-1:0][srpg_pkg::TRIG_W-1:0]      y_o,
  output logic [LANES-1:0]                            neg_o,
  output logic [TAG_W-1:0]                            tag_o
);
  import srpg_pkg::*;

  logic [TAG_W-1:0] tag1_q, tag2_q, tag3_q, tag4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
    end
  end

  assign tag_o = tag4_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [30:0] z_d;
    logic [30:0] z1_q, z2_q, z3_q;
    logic [1:0]  q1_q, q2_q, q3_q, q4_q;
    logic [61:0] zz_q, pc_q, pk_q, py_q;
    logic [30:0] w2_q;
    logic [30:0] w_d, k1_d, k2_d;

    assign z_d  = p_i[l][30] ? (Q30_ONE - {1'b0, p_i[l][29:0]}) : {1'b0, p_i[l][29:0]};
    assign w_d  = zz_q[60:30];
    assign k1_d = SIN_B - pc_q[60:30];
    assign k2_d = SIN_A - pk_q[60:30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z1_q <= z_d;
        q1_q <= p_i[l][31:30];
        zz_q <= 62'(z_d) * 62'(z_d);
        z2_q <= z1_q;
        q2_q <= q1_q;
        w2_q <= w_d;
        pc_q <= 62'(w_d) * 62'(SIN_C);
        z3_q <= z2_q;
        q3_q <= q2_q;
        pk_q <= 62'(w2_q) * 62'(k1_d);
        q4_q <= q3_q;
        py_q <= 62'(z3_q) * 62'(k2_d);
      end
    end

    assign y_o[l]   = py_q[60:30];
    assign neg_o[l] = q4_q[1];
  end

endmodule

>>> design/srpg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module srpg_div #(
  parameter int TAG_W = 1
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [srpg_pkg::NUM_W-1:0]    num_i,
  input  logic [srpg_pkg::DEN_W-1:0]    den_i,
  input  logic [TAG_W-1:0]              tag_i,
  output logic [srpg_pkg::QUOT_W-1:0]   quo_o,
  output logic                          sat_o,
  output logic [TAG_W-1:0]              tag_o
);
  import srpg_pkg::*;

  localparam int DSH_W = DEN_W + QUOT_W;

  logic [REM_W-1:0]  rem_q [QUOT_W+1];
  logic [DEN_W-1:0]  den_q [QUOT_W+1];
  logic [QUOT_W-1:0] quo_q [QUOT_W+1];
  logic              sat_q [QUOT_W+1];
  logic [TAG_W-1:0]  tag_q [QUOT_W+1];

  // quotient of num * 2^QUOT_W / den overflows when num >= den
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {num_i, {QUOT_W{1'b0}}};
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= (DEN_W'(num_i) >= den_i);
      tag_q[0] <= tag_i;
    end
  end

  for (genvar s = 1; s <= QUOT_W; s++) begin : g_st
    localparam int J = QUOT_W - s;
    logic [DSH_W-1:0] dsh;
    logic             ge;

    assign dsh = DSH_W'(den_q[s-1]) << J;
    assign ge  = (DSH_W'(rem_q[s-1]) >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? REM_W'(DSH_W'(rem_q[s-1]) - dsh) : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= {quo_q[s-1][QUOT_W-2:0], ge};
        sat_q[s] <= sat_q[s-1];
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[QUOT_W];
  assign sat_o = sat_q[QUOT_W];
  assign tag_o = tag_q[QUOT_W];

endmodule
